FILE: design/igpc_pkg.sv
// Shared constants and types for the ideal gas primitive converter.
`default_nettype none

package igpc_pkg;

   localparam int DEF_FRAC_BITS   = 16;
   localparam int DEF_VALUE_WIDTH = 48;

   // Gamma is unsigned Q2.16, 1/R is unsigned Q0.32.
   localparam int GAMMA_WIDTH = 18;
   localparam int GAMMA_FRAC  = 16;
   localparam int INV_WIDTH   = 32;
   localparam int DIMS_WIDTH  = 2;

   // Reset values: gamma 1.4, 1/287.058, three dimensions.
   localparam logic [GAMMA_WIDTH-1:0] GAMMA_RESET = 18'd91750;
   localparam logic [INV_WIDTH-1:0]   INV_RESET   = 32'd14962019;
   localparam logic [DIMS_WIDTH-1:0]  DIMS_RESET  = 2'd3;
   localparam logic [GAMMA_WIDTH-1:0] GAMMA_ONE   = 18'd65536;

   typedef enum logic [1:0] {
      REG_GAMMA   = 2'd0,
      REG_INV_GAS = 2'd1,
      REG_DIMS    = 2'd2
   } csr_reg_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_DENSITY  = 2'd1,
      STATUS_PRESSURE = 2'd2
   } status_type;

endpackage

`default_nettype wire

FILE: design/igpc_mul.sv
// Two-stage unsigned multiplier built from four registered partial products.
`default_nettype none

module igpc_mul #(
   parameter int AW = 48,
   parameter int BW = 48
) (
   input  logic             clock,
   input  logic [AW-1:0]    a,
   input  logic [BW-1:0]    b,
   output logic [AW+BW-1:0] prod
);

   localparam int AL = AW / 2;
   localparam int AH = AW - AL;
   localparam int BL = BW / 2;
   localparam int BH = BW - BL;
   localparam int PW = AW + BW;

   logic [AL+BL-1:0] ll_ff;
   logic [AL+BH-1:0] lh_ff;
   logic [AH+BL-1:0] hl_ff;
   logic [AH+BH-1:0] hh_ff;
   logic [PW-1:0]    prod_ff;

   always_ff @(posedge clock) begin
      ll_ff <= (AL+BL)'(a[AL-1:0]) * (AL+BL)'(b[BL-1:0]);
      lh_ff <= (AL+BH)'(a[AL-1:0]) * (AL+BH)'(b[BW-1:BL]);
      hl_ff <= (AH+BL)'(a[AW-1:AL]) * (AH+BL)'(b[BL-1:0]);
      hh_ff <= (AH+BH)'(a[AW-1:AL]) * (AH+BH)'(b[BW-1:BL]);
      prod_ff <= PW'(ll_ff) + (PW'(lh_ff) << BL) + (PW'(hl_ff) << AL)
                 + (PW'(hh_ff) << (AL + BL));
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

FILE: design/igpc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
`default_nettype none

module igpc_div #(
   parameter int N = 96,
   parameter int D = 48,
   parameter int Q = 48
) (
   input  logic         clock,
   input  logic [N-1:0] dividend,
   input  logic [D-1:0] divisor,
   output logic [Q-1:0] quotient,
   output logic         overflow
);

   localparam int HW = (N > Q) ? N - Q : 1;
   localparam int CW = ((HW > D) ? HW : D) + 1;

   logic [Q+HW-1:0] ext;
   logic [HW-1:0]   high;
   logic            ovf_in;

   logic [D-1:0] rem_ff [0:Q];
   logic [D-1:0] dsr_ff [0:Q];
   logic [Q-1:0] low_ff [0:Q];
   logic [Q-1:0] quo_ff [0:Q];
   logic         ovf_ff [0:Q];

   assign ext    = (Q+HW)'(dividend);
   assign high   = ext[Q+HW-1:Q];
   assign ovf_in = CW'(high) >= CW'(divisor);

   always_ff @(posedge clock) begin
      rem_ff[0] <= ovf_in ? '0 : D'(high);
      dsr_ff[0] <= divisor;
      low_ff[0] <= ext[Q-1:0];
      quo_ff[0] <= '0;
      ovf_ff[0] <= ovf_in;
   end

   for (genvar i = 1; i <= Q; i++) begin : g_stage
      logic [D:0] trial;
      logic       ge;

      assign trial = {rem_ff[i-1], low_ff[i-1][Q-1]};
      assign ge    = trial >= {1'b0, dsr_ff[i-1]};

      always_ff @(posedge clock) begin
         rem_ff[i] <= ge ? D'(trial - {1'b0, dsr_ff[i-1]}) : D'(trial);
         dsr_ff[i] <= dsr_ff[i-1];
         low_ff[i] <= low_ff[i-1] << 1;
         quo_ff[i] <= {quo_ff[i-1][Q-2:0], ge};
         ovf_ff[i] <= ovf_ff[i-1];
      end
   end

   assign quotient = quo_ff[Q];
   assign overflow = ovf_ff[Q];

endmodule

`default_nettype wire

FILE: design/igpc_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module igpc_sqrt #(
   parameter int R = 47
) (
   input  logic           clock,
   input  logic [2*R-1:0] radicand,
   output logic [R-1:0]   root
);

   logic [2*R-1:0] x_ff    [0:R];
   logic [R:0]     rem_ff  [0:R];
   logic [R-1:0]   root_ff [0:R];

   always_ff @(posedge clock) begin
      x_ff[0]    <= radicand;
      rem_ff[0]  <= '0;
      root_ff[0] <= '0;
   end

   for (genvar i = 1; i <= R; i++) begin : g_stage
      logic [R+2:0] cur;
      logic [R+2:0] trial;
      logic         ge;

      assign cur   = {rem_ff[i-1], x_ff[i-1][2*R-1:2*R-2]};
      assign trial = (R+3)'({root_ff[i-1], 2'b01});
      assign ge    = cur >= trial;

      always_ff @(posedge clock) begin
         rem_ff[i]  <= ge ? (R+1)'(cur - trial) : (R+1)'(cur);
         root_ff[i] <= {root_ff[i-1][R-2:0], ge};
         x_ff[i]    <= x_ff[i-1] << 2;
      end
   end

   assign root = root_ff[R];

endmodule

`default_nettype wire

FILE: design/igpc_delay.sv
// Fixed-length register delay line for pipeline alignment.
`default_nettype none

module igpc_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   if (DEPTH == 0) begin : g_none
      assign dout = din;
   end else begin : g_line
      logic [WIDTH-1:0] tap_ff [0:DEPTH-1];

      always_ff @(posedge clock) begin
         tap_ff[0] <= din;
      end

      for (genvar i = 1; i < DEPTH; i++) begin : g_tap
         always_ff @(posedge clock) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end

      assign dout = tap_ff[DEPTH-1];
   end

endmodule

`default_nettype wire

FILE: design/ideal_gas_primitive_converter_core.sv
// Top level: conserved to primitive variable conversion for an ideal gas.
//
// Requests enter on start with the req_ fields; busy is always low, so a new
// request is taken in every cycle. Each request yields exactly one result,
// shown on the rsp_ ports for one cycle with rsp_valid high. Throughput is
// one request per clock. The pipeline depth is set mainly by the chain of
// one-bit-per-stage units (kinetic energy divide, sound speed divide and
// square root, Mach divide), with the pressure multiply in between.
// The receiver cannot stall the result channel; nothing is held back.
// Configuration (gamma, 1/R, dimension count) goes through the APB-style
// port at byte addresses 0, 4 and 8. The user must write it only while idle;
// the block itself does not enforce this. Synchronous reset clears the
// valid pipeline and restores the register defaults; data still in flight
// is dropped. status: 0 ok, 1 density not positive, 2 negative pressure;
// the six derived outputs are zero whenever status is nonzero.
`default_nettype none

module ideal_gas_primitive_converter_core
   import igpc_pkg::*;
#(
   parameter int FRAC_BITS   = DEF_FRAC_BITS,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic        [VALUE_WIDTH-2:0] req_density,
   input  logic signed [VALUE_WIDTH-1:0] req_momentum_x,
   input  logic signed [VALUE_WIDTH-1:0] req_momentum_y,
   input  logic signed [VALUE_WIDTH-1:0] req_momentum_z,
   input  logic signed [VALUE_WIDTH-1:0] req_total_energy,
   output logic                          rsp_valid,
   output logic signed [VALUE_WIDTH-1:0] rsp_pressure,
   output logic signed [VALUE_WIDTH-1:0] rsp_enthalpy,
   output logic signed [VALUE_WIDTH-1:0] rsp_temperature,
   output logic        [VALUE_WIDTH-2:0] rsp_sound_speed,
   output logic        [VALUE_WIDTH-2:0] rsp_speed,
   output logic        [VALUE_WIDTH-2:0] rsp_mach,
   output logic                    [1:0] rsp_status,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic                    [3:0] paddr,
   input  logic                   [31:0] pwdata,
   output logic                   [31:0] prdata,
   output logic                          pready
);

   localparam int W  = VALUE_WIDTH;
   localparam int VW = W - 1;
   localparam int F  = FRAC_BITS;
   localparam int GW = GAMMA_WIDTH;

   // Cycle at which each value sits in a register, counted from acceptance.
   localparam int T_IN  = 1;
   localparam int T_SQ  = T_IN + 2;
   localparam int T_S   = T_SQ + 1;
   localparam int T_K   = T_S + W + 1;
   localparam int T_PRE = T_K + 1;
   localparam int T_P   = T_PRE + 3;
   localparam int T_H   = T_P + VW + 1;
   localparam int T_T   = T_P + 2 + VW + 1;
   localparam int T_CD  = T_P + 2 + 2 * VW + 1;
   localparam int T_C   = T_CD + VW + 1;
   localparam int T_VD  = T_S + 2 * VW + 1;
   localparam int T_V   = T_VD + VW + 1;
   localparam int T_M   = T_C + VW + 1;
   localparam int T_OUT = T_M + 1;

   localparam logic [VW-1:0] VMAX = '1;

   // ---------------- configuration registers ----------------
   logic [GW-1:0]         gamma_ff, gamma_in;
   logic [INV_WIDTH-1:0]  inv_gas_ff, inv_gas_in;
   logic [DIMS_WIDTH-1:0] dims_ff, dims_in;
   logic                  csr_write;
   csr_reg_type           csr_index;

   assign csr_write = psel && penable && pwrite;
   assign csr_index = csr_reg_type'(paddr[3:2]);
   assign pready    = 1'b1;

   always_comb begin
      gamma_in   = gamma_ff;
      inv_gas_in = inv_gas_ff;
      dims_in    = dims_ff;
      prdata     = '0;
      case (csr_index)
         REG_GAMMA: begin
            prdata = 32'(gamma_ff);
            if (csr_write) gamma_in = pwdata[GW-1:0];
         end
         REG_INV_GAS: begin
            prdata = inv_gas_ff;
            if (csr_write) inv_gas_in = pwdata;
         end
         REG_DIMS: begin
            prdata = 32'(dims_ff);
            if (csr_write) dims_in = pwdata[DIMS_WIDTH-1:0];
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff   <= GAMMA_RESET;
         inv_gas_ff <= INV_RESET;
         dims_ff    <= DIMS_RESET;
      end else begin
         gamma_ff   <= gamma_in;
         inv_gas_ff <= inv_gas_in;
         dims_ff    <= dims_in;
      end
   end

   // ---------------- valid pipeline ----------------
   logic accept;
   logic valid_ff [0:T_OUT-1];

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < T_OUT; i++) valid_ff[i] <= 1'b0;
      end else begin
         valid_ff[0] <= accept;
         for (int i = 1; i < T_OUT; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   // ---------------- input stage: magnitudes ----------------
   logic [VW-1:0] rho_ff;
   logic [W-1:0]  mx_ff, my_ff, mz_ff, emag_ff;
   logic          eneg_ff, rho0_ff;
   logic          use_y, use_z;

   assign use_y = dims_ff >= 2'd2;
   assign use_z = dims_ff == 2'd3;

   always_ff @(posedge clock) begin
      rho_ff  <= req_density;
      rho0_ff <= req_density == '0;
      mx_ff   <= req_momentum_x[W-1] ? $unsigned(-req_momentum_x) : $unsigned(req_momentum_x);
      my_ff   <= !use_y ? '0 :
                 req_momentum_y[W-1] ? $unsigned(-req_momentum_y) : $unsigned(req_momentum_y);
      mz_ff   <= !use_z ? '0 :
                 req_momentum_z[W-1] ? $unsigned(-req_momentum_z) : $unsigned(req_momentum_z);
      emag_ff <= req_total_energy[W-1] ? $unsigned(-req_total_energy)
                                       : $unsigned(req_total_energy);
      eneg_ff <= req_total_energy[W-1];
   end

   // ---------------- squares and density squared ----------------
   logic [2*W-1:0]  sqx, sqy, sqz;
   logic [2*VW-1:0] rho2, rho2_s;
   logic [2*W-1:0]  s_ff;
   logic [VW-1:0]   rho_s;

   igpc_mul #(.AW(W), .BW(W)) u_sqx (.clock(clock), .a(mx_ff), .b(mx_ff), .prod(sqx));
   igpc_mul #(.AW(W), .BW(W)) u_sqy (.clock(clock), .a(my_ff), .b(my_ff), .prod(sqy));
   igpc_mul #(.AW(W), .BW(W)) u_sqz (.clock(clock), .a(mz_ff), .b(mz_ff), .prod(sqz));
   igpc_mul #(.AW(VW), .BW(VW)) u_rho2 (.clock(clock), .a(rho_ff), .b(rho_ff), .prod(rho2));

   always_ff @(posedge clock) begin
      s_ff <= sqx + sqy + sqz;
   end

   igpc_delay #(.WIDTH(2*VW), .DEPTH(T_S - T_SQ)) u_d_rho2 (
      .clock(clock), .din(rho2), .dout(rho2_s));
   igpc_delay #(.WIDTH(VW), .DEPTH(T_S - T_IN)) u_d_rho_s (
      .clock(clock), .din(rho_ff), .dout(rho_s));

   // ---------------- kinetic energy S / (2 rho) ----------------
   logic [W-1:0] kin;
   logic         kin_ovf;
   logic [W-1:0] emag_k;
   logic         eneg_k;

   igpc_div #(.N(2*W), .D(W), .Q(W)) u_div_k (
      .clock(clock), .dividend(s_ff), .divisor({rho_s, 1'b0}),
      .quotient(kin), .overflow(kin_ovf));

   igpc_delay #(.WIDTH(W+1), .DEPTH(T_K - T_IN)) u_d_emag_k (
      .clock(clock), .din({eneg_ff, emag_ff}), .dout({eneg_k, emag_k}));

   logic [W-1:0] inner_ff;
   logic         neg_ff;

   always_ff @(posedge clock) begin
      inner_ff <= emag_k - kin;
      neg_ff   <= eneg_k || kin_ovf || (kin > emag_k);
   end

   // ---------------- pressure ----------------
   logic [GW-1:0]   gm1;
   logic [GW+W-1:0] p_prod;
   logic [VW-1:0]   p_ff;

   assign gm1 = (gamma_ff > GAMMA_ONE) ? gamma_ff - GAMMA_ONE : '0;

   igpc_mul #(.AW(GW), .BW(W)) u_mul_p (
      .clock(clock), .a(gm1), .b(inner_ff), .prod(p_prod));

   always_ff @(posedge clock) begin
      p_ff <= (|p_prod[GW+W-1:GAMMA_FRAC+VW]) ? VMAX : p_prod[GAMMA_FRAC+VW-1:GAMMA_FRAC];
   end

   // ---------------- enthalpy (E + p) / rho ----------------
   logic [W-1:0]   emag_p;
   logic [VW-1:0]  rho_p, rho_p2;
   logic [W:0]     eplus;
   logic [VW-1:0]  enth_q, enth_val, enth_m;
   logic           enth_ovf;

   igpc_delay #(.WIDTH(W), .DEPTH(T_P - T_IN)) u_d_emag_p (
      .clock(clock), .din(emag_ff), .dout(emag_p));
   igpc_delay #(.WIDTH(VW), .DEPTH(T_P - T_IN)) u_d_rho_p (
      .clock(clock), .din(rho_ff), .dout(rho_p));

   assign eplus = (W+1)'(emag_p) + (W+1)'(p_ff);

   igpc_div #(.N(W+1+F), .D(VW), .Q(VW)) u_div_h (
      .clock(clock), .dividend((W+1+F)'(eplus) << F), .divisor(rho_p),
      .quotient(enth_q), .overflow(enth_ovf));

   assign enth_val = enth_ovf ? VMAX : enth_q;

   igpc_delay #(.WIDTH(VW), .DEPTH(T_M - T_H)) u_d_enth (
      .clock(clock), .din(enth_val), .dout(enth_m));

   // ---------------- temperature p / (rho R) ----------------
   logic [VW+INV_WIDTH-1:0] t_prod;
   logic [VW-1:0]           temp_q, temp_val, temp_m;
   logic                    temp_ovf;

   igpc_mul #(.AW(VW), .BW(INV_WIDTH)) u_mul_t (
      .clock(clock), .a(p_ff), .b(inv_gas_ff), .prod(t_prod));
   igpc_delay #(.WIDTH(VW), .DEPTH(2)) u_d_rho_p2 (
      .clock(clock), .din(rho_p), .dout(rho_p2));

   igpc_div #(.N(VW+F), .D(VW), .Q(VW)) u_div_t (
      .clock(clock), .dividend(t_prod[VW+INV_WIDTH-1:INV_WIDTH-F]), .divisor(rho_p2),
      .quotient(temp_q), .overflow(temp_ovf));

   assign temp_val = temp_ovf ? VMAX : temp_q;

   igpc_delay #(.WIDTH(VW), .DEPTH(T_M - T_T)) u_d_temp (
      .clock(clock), .din(temp_val), .dout(temp_m));

   // ---------------- sound speed sqrt(gamma p / rho) ----------------
   localparam int CN = GW + VW + 2 * F - GAMMA_FRAC;

   logic [GW+VW-1:0] c_prod;
   logic [2*VW-1:0]  c2_q;
   logic             c2_ovf, c2_ovf_c;
   logic [VW-1:0]    c_root, c_val, c_m;

   igpc_mul #(.AW(GW), .BW(VW)) u_mul_c (
      .clock(clock), .a(gamma_ff), .b(p_ff), .prod(c_prod));

   igpc_div #(.N(CN), .D(VW), .Q(2*VW)) u_div_c (
      .clock(clock), .dividend(CN'(c_prod) << (2 * F - GAMMA_FRAC)), .divisor(rho_p2),
      .quotient(c2_q), .overflow(c2_ovf));

   igpc_sqrt #(.R(VW)) u_sqrt_c (.clock(clock), .radicand(c2_q), .root(c_root));
   igpc_delay #(.WIDTH(1), .DEPTH(T_C - T_CD)) u_d_c2_ovf (
      .clock(clock), .din(c2_ovf), .dout(c2_ovf_c));

   assign c_val = c2_ovf_c ? VMAX : c_root;

   igpc_delay #(.WIDTH(VW), .DEPTH(T_M - T_C)) u_d_c (
      .clock(clock), .din(c_val), .dout(c_m));

   // ---------------- speed sqrt(S / rho^2) ----------------
   localparam int VN = 2 * W + 2 * F;

   logic [2*VW-1:0] v2_q;
   logic            v2_ovf, v2_ovf_v;
   logic [VW-1:0]   v_root, v_val, v_c, v_m;

   igpc_div #(.N(VN), .D(2*VW), .Q(2*VW)) u_div_v (
      .clock(clock), .dividend(VN'(s_ff) << (2 * F)), .divisor(rho2_s),
      .quotient(v2_q), .overflow(v2_ovf));

   igpc_sqrt #(.R(VW)) u_sqrt_v (.clock(clock), .radicand(v2_q), .root(v_root));
   igpc_delay #(.WIDTH(1), .DEPTH(T_V - T_VD)) u_d_v2_ovf (
      .clock(clock), .din(v2_ovf), .dout(v2_ovf_v));

   assign v_val = v2_ovf_v ? VMAX : v_root;

   igpc_delay #(.WIDTH(VW), .DEPTH(T_C - T_V)) u_d_v_c (
      .clock(clock), .din(v_val), .dout(v_c));
   igpc_delay #(.WIDTH(VW), .DEPTH(T_M - T_C)) u_d_v_m (
      .clock(clock), .din(v_c), .dout(v_m));

   // ---------------- Mach speed / c ----------------
   logic [VW-1:0] mach_q, mach_val;
   logic          mach_ovf;

   igpc_div #(.N(VW+F), .D(VW), .Q(VW)) u_div_m (
      .clock(clock), .dividend((VW+F)'(v_c) << F), .divisor(c_val),
      .quotient(mach_q), .overflow(mach_ovf));

   // Zero sound speed overflows the divider; zero speed still gives zero.
   assign mach_val = (v_m == '0) ? '0 : (mach_ovf ? VMAX : mach_q);

   // ---------------- status and output register ----------------
   logic [VW-1:0] p_m;
   logic          rho0_m, neg_m;
   status_type    status_in;

   igpc_delay #(.WIDTH(VW), .DEPTH(T_M - T_P)) u_d_p (
      .clock(clock), .din(p_ff), .dout(p_m));
   igpc_delay #(.WIDTH(1), .DEPTH(T_M - T_IN)) u_d_rho0 (
      .clock(clock), .din(rho0_ff), .dout(rho0_m));
   igpc_delay #(.WIDTH(1), .DEPTH(T_M - T_PRE)) u_d_neg (
      .clock(clock), .din(neg_ff), .dout(neg_m));

   assign status_in = rho0_m ? STATUS_DENSITY : (neg_m ? STATUS_PRESSURE : STATUS_OK);

   logic [VW-1:0] p_out_ff, h_out_ff, t_out_ff, c_out_ff, v_out_ff, m_out_ff;
   status_type    status_ff;
   logic          ok;

   assign ok = status_in == STATUS_OK;

   always_ff @(posedge clock) begin
      p_out_ff  <= ok ? p_m : '0;
      h_out_ff  <= ok ? enth_m : '0;
      t_out_ff  <= ok ? temp_m : '0;
      c_out_ff  <= ok ? c_m : '0;
      v_out_ff  <= ok ? v_m : '0;
      m_out_ff  <= ok ? mach_val : '0;
      status_ff <= status_in;
   end

   assign rsp_valid       = valid_ff[T_OUT-1];
   assign rsp_pressure    = signed'({1'b0, p_out_ff});
   assign rsp_enthalpy    = signed'({1'b0, h_out_ff});
   assign rsp_temperature = signed'({1'b0, t_out_ff});
   assign rsp_sound_speed = c_out_ff;
   assign rsp_speed       = v_out_ff;
   assign rsp_mach        = m_out_ff;
   assign rsp_status      = status_ff;

`ifndef SYNTHESIS
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |->
         rsp_pressure == '0 && rsp_enthalpy == '0 && rsp_temperature == '0 &&
         rsp_sound_speed == '0 && rsp_speed == '0 && rsp_mach == '0)
      else $error("derived outputs not cleared on fault status");

   a_mach_still: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OK && rsp_speed == '0 |-> rsp_mach == '0)
      else $error("nonzero Mach number at zero speed");

   a_nonneg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_pressure[W-1] && !rsp_enthalpy[W-1] && !rsp_temperature[W-1])
      else $error("negative signed result");

   a_dims_write: assert property (@(posedge clock) disable iff (reset)
      csr_write && csr_index == REG_DIMS |=> dims_ff == $past(pwdata[DIMS_WIDTH-1:0]))
      else $error("dimension register write lost");
`endif

endmodule

`default_nettype wire
